[src/tbo_pkg.sv]
// ----------------------------------------------------------------------------
// tbo_pkg: shared types and constants for the triangle/box overlap test
// Holds the default coordinate width and the sign code used by orientation
// results.
// ----------------------------------------------------------------------------
package tbo_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  // Sign of a value: negative, zero, or (neither) positive.
  typedef struct packed {
    logic neg;
    logic zero;
  } sgn_t;

  // Sign of the product of two signed values, given their signs.
  function automatic sgn_t sgn_mul(input sgn_t a, input sgn_t b);
    sgn_t r;
    r.zero = a.zero | b.zero;
    r.neg  = ~r.zero & (a.neg ^ b.neg);
    return r;
  endfunction

  // Sign of the negated value.
  function automatic sgn_t sgn_neg(input sgn_t a);
    sgn_t r;
    r.zero = a.zero;
    r.neg  = ~a.zero & ~a.neg;
    return r;
  endfunction

  // Sign of a - b.
  function automatic sgn_t sgn_cmp(input logic signed [63:0] a,
                                   input logic signed [63:0] b);
    sgn_t r;
    r.zero = (a == b);
    r.neg  = (a < b);
    return r;
  endfunction

endpackage

[src/tbo_orient.sv]
// ----------------------------------------------------------------------------
// tbo_orient: two-stage orientation sign unit
// Computes the sign of ex*cy - ey*cx. The products are registered first, the
// difference and its sign in the second stage.
// ----------------------------------------------------------------------------
module tbo_orient
  import tbo_pkg::*;
#(
  parameter int W = COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic signed [W:0]  ex,
  input  logic signed [W:0]  ey,
  input  logic signed [W:0]  cx,
  input  logic signed [W:0]  cy,
  output sgn_t               sgn
);

  localparam int P = 2 * (W + 1);

  logic signed [P-1:0] p1;
  logic signed [P-1:0] p2;
  logic signed [P:0]   diff;

  always_ff @(posedge clk) begin
    p1 <= ex * cy;
    p2 <= ey * cx;
  end

  assign diff = $signed({p1[P-1], p1}) - $signed({p2[P-1], p2});

  always_ff @(posedge clk) begin
    sgn.neg  <= diff[P];
    sgn.zero <= (diff == '0);
  end

endmodule

[src/triangle_box_overlap_2d.sv]
// A request accepted at a clock edge gives its result on done. Throughput:
// one request per cycle; busy is always low. The datapath has four register
// stages: differences and compares, products, orientation signs, final
// decision.
// Reset (rst, synchronous) clears the valid bits only; requests in flight
// are dropped. The receiver cannot stall, so nothing ever backs up.
// ----------------------------------------------------------------------------
// triangle_box_overlap_2d: pipelined 2D triangle versus rectangle test
// Decides whether a triangle and an axis-aligned rectangle touch, boundaries
// included, using exact integer orientation tests.
// ----------------------------------------------------------------------------
module triangle_box_overlap_2d
  import tbo_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] v0_x,
  input  logic signed [COORD_WIDTH-1:0] v0_y,
  input  logic signed [COORD_WIDTH-1:0] v1_x,
  input  logic signed [COORD_WIDTH-1:0] v1_y,
  input  logic signed [COORD_WIDTH-1:0] v2_x,
  input  logic signed [COORD_WIDTH-1:0] v2_y,
  input  logic signed [COORD_WIDTH-1:0] box_x_low,
  input  logic signed [COORD_WIDTH-1:0] box_y_low,
  input  logic signed [COORD_WIDTH-1:0] box_x_high,
  input  logic signed [COORD_WIDTH-1:0] box_y_high,
  output logic                          done,
  output logic                          overlap
);

  localparam int W = COORD_WIDTH;

  // Side information computed in the first stage and carried alongside the
  // orientation units until the decision stage.
  typedef struct packed {
    logic                  apart;   // bounding boxes are disjoint
    logic                  inbox;   // some vertex lies in the rectangle
    logic [11:0]           proj;    // projections overlap, per edge pair
    sgn_t [3:0][2:0]       bs;      // box edge j against triangle vertex i
  } aux_t;

  logic signed [W-1:0] tx [3];
  logic signed [W-1:0] ty [3];
  logic signed [W-1:0] rx [4];
  logic signed [W-1:0] ry [4];

  assign tx[0] = v0_x;
  assign ty[0] = v0_y;
  assign tx[1] = v1_x;
  assign ty[1] = v1_y;
  assign tx[2] = v2_x;
  assign ty[2] = v2_y;
  // Corners in order: low-low, high-low, high-high, low-high.
  assign rx[0] = box_x_low;
  assign ry[0] = box_y_low;
  assign rx[1] = box_x_high;
  assign ry[1] = box_y_low;
  assign rx[2] = box_x_high;
  assign ry[2] = box_y_high;
  assign rx[3] = box_x_low;
  assign ry[3] = box_y_high;

  // The block never refuses a request.
  assign busy = 1'b0;

  logic v1, v2, v3;
  aux_t aux_next, aux1, aux2, aux3;

  // Stage 1 registers: edge vectors and corner offsets for the 12
  // orientation tests of triangle edge i against box corner j.
  logic signed [W:0] ex1 [12];
  logic signed [W:0] ey1 [12];
  logic signed [W:0] cx1 [12];
  logic signed [W:0] cy1 [12];
  sgn_t              osg [12];

  always_comb begin
    logic ax_lo, ax_hi, ay_lo, ay_hi;
    sgn_t sx, sy;
    int   b;
    ax_lo = 1'b1;
    ax_hi = 1'b1;
    ay_lo = 1'b1;
    ay_hi = 1'b1;
    aux_next.inbox = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ax_lo = ax_lo & (tx[i] < box_x_low);
      ax_hi = ax_hi & (tx[i] > box_x_high);
      ay_lo = ay_lo & (ty[i] < box_y_low);
      ay_hi = ay_hi & (ty[i] > box_y_high);
      aux_next.inbox = aux_next.inbox |
        ((tx[i] >= box_x_low) & (tx[i] <= box_x_high) &
         (ty[i] >= box_y_low) & (ty[i] <= box_y_high));
    end
    aux_next.apart = ax_lo | ax_hi | ay_lo | ay_hi;

    // Box edges are axis-aligned, so their cross products with a vertex
    // reduce to the product of two compare signs.
    for (int i = 0; i < 3; i++) begin
      sx = sgn_cmp(64'(box_x_high), 64'(box_x_low));
      sy = sgn_cmp(64'(ty[i]), 64'(box_y_low));
      aux_next.bs[0][i] = sgn_mul(sx, sy);
      sx = sgn_cmp(64'(box_y_high), 64'(box_y_low));
      sy = sgn_cmp(64'(tx[i]), 64'(box_x_high));
      aux_next.bs[1][i] = sgn_neg(sgn_mul(sx, sy));
      sx = sgn_cmp(64'(box_x_low), 64'(box_x_high));
      sy = sgn_cmp(64'(ty[i]), 64'(box_y_high));
      aux_next.bs[2][i] = sgn_mul(sx, sy);
      sx = sgn_cmp(64'(box_y_low), 64'(box_y_high));
      sy = sgn_cmp(64'(tx[i]), 64'(box_x_low));
      aux_next.bs[3][i] = sgn_neg(sgn_mul(sx, sy));
    end

    // Collinear fallback: closed x and y ranges of the two segments overlap.
    // min(a,b) <= max(c,d) holds exactly when some end is <= some other end.
    for (int i = 0; i < 3; i++) begin
      b = (i + 1) % 3;
      for (int j = 0; j < 4; j++) begin
        aux_next.proj[i*4+j] =
          ((tx[i] <= rx[j]) | (tx[i] <= rx[(j+1)%4]) |
           (tx[b] <= rx[j]) | (tx[b] <= rx[(j+1)%4])) &
          ((rx[j] <= tx[i]) | (rx[j] <= tx[b]) |
           (rx[(j+1)%4] <= tx[i]) | (rx[(j+1)%4] <= tx[b])) &
          ((ty[i] <= ry[j]) | (ty[i] <= ry[(j+1)%4]) |
           (ty[b] <= ry[j]) | (ty[b] <= ry[(j+1)%4])) &
          ((ry[j] <= ty[i]) | (ry[j] <= ty[b]) |
           (ry[(j+1)%4] <= ty[i]) | (ry[(j+1)%4] <= ty[b]));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        ex1[i*4+j] <= $signed({tx[(i+1)%3][W-1], tx[(i+1)%3]}) -
                      $signed({tx[i][W-1], tx[i]});
        ey1[i*4+j] <= $signed({ty[(i+1)%3][W-1], ty[(i+1)%3]}) -
                      $signed({ty[i][W-1], ty[i]});
        cx1[i*4+j] <= $signed({rx[j][W-1], rx[j]}) - $signed({tx[i][W-1], tx[i]});
        cy1[i*4+j] <= $signed({ry[j][W-1], ry[j]}) - $signed({ty[i][W-1], ty[i]});
      end
    end
    aux1 <= aux_next;
    aux2 <= aux1;
    aux3 <= aux2;
  end

  // Stages 2 and 3: one orientation unit per triangle edge and box corner.
  for (genvar k = 0; k < 12; k++) begin : g_orient
    tbo_orient #(.W(W)) u_orient (
      .clk (clk),
      .ex  (ex1[k]),
      .ey  (ey1[k]),
      .cx  (cx1[k]),
      .cy  (cy1[k]),
      .sgn (osg[k])
    );
  end

  // Stage 4: combine. A corner is inside the triangle when no edge sign is
  // negative or no edge sign is positive. An edge pair crosses when neither
  // side pair shares a strict sign, unless it is collinear.
  logic hit;

  always_comb begin
    logic no_neg, no_pos, ctri, seg, coll, x12, x34;
    sgn_t s1, s2, s3, s4;
    ctri = 1'b0;
    for (int j = 0; j < 4; j++) begin
      no_neg = 1'b1;
      no_pos = 1'b1;
      for (int i = 0; i < 3; i++) begin
        no_neg = no_neg & ~osg[i*4+j].neg;
        no_pos = no_pos & (osg[i*4+j].neg | osg[i*4+j].zero);
      end
      ctri = ctri | no_neg | no_pos;
    end
    seg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        s1   = osg[i*4+j];
        s2   = osg[i*4+(j+1)%4];
        s3   = aux3.bs[j][i];
        s4   = aux3.bs[j][(i+1)%3];
        coll = s1.zero & s2.zero;
        x12  = ~((~s1.zero & ~s1.neg & ~s2.zero & ~s2.neg) | (s1.neg & s2.neg));
        x34  = ~((~s3.zero & ~s3.neg & ~s4.zero & ~s4.neg) | (s3.neg & s4.neg));
        seg  = seg | (coll ? aux3.proj[i*4+j] : (x12 & x34));
      end
    end
    hit = ~aux3.apart & (aux3.inbox | ctri | seg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start & ~busy;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
    overlap <= hit;
  end

endmodule

[src/tbo_checker.sv]
// ----------------------------------------------------------------------------
// tbo_checker: port-level checks for triangle_box_overlap_2d
// Watches request and result timing and one obvious rejection case.
// ----------------------------------------------------------------------------
module tbo_checker
  import tbo_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic signed [COORD_WIDTH-1:0] v0_x,
  input logic signed [COORD_WIDTH-1:0] v1_x,
  input logic signed [COORD_WIDTH-1:0] v2_x,
  input logic signed [COORD_WIDTH-1:0] box_x_low,
  input logic                          done,
  input logic                          overlap
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_req_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("request produced no result");

  a_result_has_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without request");

  a_left_reject: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && v0_x < box_x_low && v1_x < box_x_low && v2_x < box_x_low)
      |-> ##4 !overlap)
    else $error("triangle left of box reported overlap");

endmodule

bind triangle_box_overlap_2d tbo_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tbo_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .v0_x      (v0_x),
  .v1_x      (v1_x),
  .v2_x      (v2_x),
  .box_x_low (box_x_low),
  .done      (done),
  .overlap   (overlap)
);

[dv/tb_triangle_box_overlap_2d.sv]
// ----------------------------------------------------------------------------
// tb_triangle_box_overlap_2d: self-checking bench for the triangle/box test
// Drives directed and random triangle/rectangle requests through the command
// handshake and checks every overlap result against an exact integer
// predictor, in request order.
// ----------------------------------------------------------------------------
module tb_triangle_box_overlap_2d
  import tbo_pkg::*;
();

  localparam int CW = COORD_WIDTH_DEF;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct {
    coord_t vx[3];
    coord_t vy[3];
    coord_t xl, yl, xh, yh;
  } tri_box_t;

  // Orientation of (b - a) x (c - a), returned as -1, 0 or 1. Coordinates are
  // widened to 64 bits first, so the products are exact.
  function automatic int orient(longint ax, longint ay, longint bx, longint by,
                                longint cx, longint cy);
    longint cr;
    cr = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    return (cr > 0) ? 1 : ((cr < 0) ? -1 : 0);
  endfunction

  function automatic longint mn(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic longint mx(longint a, longint b);
    return a > b ? a : b;
  endfunction

  // Two closed segments meet; a collinear pair (including a point-like edge)
  // falls back to overlap of the x and y projections.
  function automatic bit segments_meet(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy, longint dx, longint dy);
    int s1, s2, s3, s4;
    s1 = orient(ax, ay, bx, by, cx, cy);
    s2 = orient(ax, ay, bx, by, dx, dy);
    s3 = orient(cx, cy, dx, dy, ax, ay);
    s4 = orient(cx, cy, dx, dy, bx, by);
    if (s1 == 0 && s2 == 0)
      return mn(ax, bx) <= mx(cx, dx) && mn(cx, dx) <= mx(ax, bx) &&
             mn(ay, by) <= mx(cy, dy) && mn(cy, dy) <= mx(ay, by);
    return (s1 * s2 <= 0) && (s3 * s4 <= 0);
  endfunction

  // Predicts the overlap flag with the same four stages as the block: bounding
  // box reject, vertex in box, corner in triangle, then edge crossings.
  function automatic bit predict_overlap(tri_box_t r);
    longint tx[3], ty[3], cx[4], cy[4];
    int s1, s2, s3;
    for (int i = 0; i < 3; i++) begin
      tx[i] = r.vx[i];
      ty[i] = r.vy[i];
    end
    cx[0] = r.xl; cy[0] = r.yl;
    cx[1] = r.xh; cy[1] = r.yl;
    cx[2] = r.xh; cy[2] = r.yh;
    cx[3] = r.xl; cy[3] = r.yh;
    if (mx(mx(tx[0], tx[1]), tx[2]) < r.xl || mn(mn(tx[0], tx[1]), tx[2]) > r.xh ||
        mx(mx(ty[0], ty[1]), ty[2]) < r.yl || mn(mn(ty[0], ty[1]), ty[2]) > r.yh)
      return 0;
    for (int i = 0; i < 3; i++)
      if (tx[i] >= r.xl && tx[i] <= r.xh && ty[i] >= r.yl && ty[i] <= r.yh)
        return 1;
    for (int j = 0; j < 4; j++) begin
      s1 = orient(tx[0], ty[0], tx[1], ty[1], cx[j], cy[j]);
      s2 = orient(tx[1], ty[1], tx[2], ty[2], cx[j], cy[j]);
      s3 = orient(tx[2], ty[2], tx[0], ty[0], cx[j], cy[j]);
      if ((s1 >= 0 && s2 >= 0 && s3 >= 0) || (s1 <= 0 && s2 <= 0 && s3 <= 0))
        return 1;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 4; j++)
        if (segments_meet(tx[i], ty[i], tx[(i + 1) % 3], ty[(i + 1) % 3],
                          cx[j], cy[j], cx[(j + 1) % 4], cy[(j + 1) % 4]))
          return 1;
    return 0;
  endfunction

  // Keeps the expected flags in request order and compares each result.
  class overlap_scoreboard;
    bit pending[$];
    int errors;

    function void note_request(tri_box_t r);
      pending.push_back(predict_overlap(r));
    endfunction

    function void check_result(logic got);
      bit want;
      if (pending.size() == 0) begin
        $error("overlap: result with no request waiting, actual %0b", got);
        errors++;
      end else begin
        want = pending.pop_front();
        if (got !== want) begin
          $error("overlap: expected %0b, actual %0b", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic   clk = 0;
  logic   rst = 1;
  logic   start = 0;
  logic   busy, done, overlap;
  coord_t v0_x = 0, v0_y = 0, v1_x = 0, v1_y = 0, v2_x = 0, v2_y = 0;
  coord_t box_x_low = 0, box_y_low = 0, box_x_high = 0, box_y_high = 0;

  overlap_scoreboard sb = new();
  bit quiet_tail;

  always #5 clk = ~clk;

  triangle_box_overlap_2d u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .v0_x(v0_x), .v0_y(v0_y), .v1_x(v1_x), .v1_y(v1_y), .v2_x(v2_x), .v2_y(v2_y),
    .box_x_low(box_x_low), .box_y_low(box_y_low),
    .box_x_high(box_x_high), .box_y_high(box_y_high),
    .done(done), .overlap(overlap)
  );

  // Results cannot be held off, so every strobe is checked at the edge that
  // ends its cycle.
  always @(posedge clk)
    if (!rst && done)
      sb.check_result(overlap);

  // Presents one request from the falling edge and holds it until an edge
  // with busy low takes it. An optional idle burst precedes it; start stays
  // high across back-to-back requests, so it is never lowered and raised in
  // one step.
  task automatic send_request(tri_box_t r);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    v0_x <= r.vx[0]; v0_y <= r.vy[0];
    v1_x <= r.vx[1]; v1_y <= r.vy[1];
    v2_x <= r.vx[2]; v2_y <= r.vy[2];
    box_x_low <= r.xl; box_y_low <= r.yl;
    box_x_high <= r.xh; box_y_high <= r.yh;
    start <= 1;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    @(negedge clk);
  endtask

  function automatic coord_t any_coord();
    return coord_t'($urandom());
  endfunction

  // Random request. Most use a box and triangle drawn from a shared window
  // (span 4, 200 or 30000), so every stage of the decision gets exercised; span 4
  // is a tiny grid to hit collinear and touching cases; the rest are full-range noise.
  function automatic tri_box_t random_request();
    tri_box_t r;
    int unsigned kind;
    int base, span;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      for (int i = 0; i < 3; i++) begin
        r.vx[i] = any_coord();
        r.vy[i] = any_coord();
      end
      r.xl = any_coord(); r.xh = any_coord(); r.yl = any_coord(); r.yh = any_coord();
    end else begin
      span = (kind < 5) ? 4 : ((kind < 8) ? 200 : 30000);
      base = int'($urandom_range(0, 65535)) - 32768;
      if (base > 32767 - 2 * span) base = 32767 - 2 * span;
      if (base < -32768) base = -32768;
      for (int i = 0; i < 3; i++) begin
        r.vx[i] = coord_t'(base + $urandom_range(0, 2 * span));
        r.vy[i] = coord_t'(base + $urandom_range(0, 2 * span));
      end
      r.xl = coord_t'(base + $urandom_range(0, span));
      r.yl = coord_t'(base + $urandom_range(0, span));
      r.xh = coord_t'(int'(r.xl) + $urandom_range(0, span));
      r.yh = coord_t'(int'(r.yl) + $urandom_range(0, span));
      // An occasional inverted box is applied as given by the block.
      if ($urandom_range(0, 15) == 0) begin
        r.xh = coord_t'(int'(r.xl) - $urandom_range(1, span));
      end
    end
    return r;
  endfunction

  function automatic tri_box_t make_request(int x0, int y0, int x1, int y1, int x2, int y2,
                                            int xl, int yl, int xh, int yh);
    tri_box_t r;
    r.vx[0] = coord_t'(x0); r.vy[0] = coord_t'(y0);
    r.vx[1] = coord_t'(x1); r.vy[1] = coord_t'(y1);
    r.vx[2] = coord_t'(x2); r.vy[2] = coord_t'(y2);
    r.xl = coord_t'(xl); r.yl = coord_t'(yl); r.xh = coord_t'(xh); r.yh = coord_t'(yh);
    return r;
  endfunction

  initial begin
    tri_box_t directed[$];
    int unsigned hold;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed requests: each stage deciding, touching boundaries, degenerate
    // triangles and edges, an inverted box, and the coordinate extremes.
    directed.push_back(make_request(0, 0, 10, 0, 0, 10, 20, 20, 30, 30));
    directed.push_back(make_request(5, 5, 50, 5, 5, 50, 0, 0, 10, 10));
    directed.push_back(make_request(-100, -100, 100, -100, 0, 100, -5, -5, 5, 5));
    directed.push_back(make_request(-10, 5, 20, 5, 5, 30, 0, 0, 10, 10));
    directed.push_back(make_request(0, 20, 20, 0, 20, 20, 0, 0, 10, 10));
    directed.push_back(make_request(0, 21, 21, 0, 21, 21, 0, 0, 10, 10));
    directed.push_back(make_request(10, 10, 20, 10, 20, 20, 0, 0, 10, 10));
    directed.push_back(make_request(0, 0, 5, 5, 10, 10, 3, 3, 3, 3));
    directed.push_back(make_request(0, 0, 5, 5, 10, 10, 3, 4, 3, 4));
    directed.push_back(make_request(7, 7, 7, 7, 7, 7, 0, 0, 10, 10));
    directed.push_back(make_request(-5, 15, 15, 15, 15, 15, 0, 0, 10, 10));
    directed.push_back(make_request(-5, 10, 15, 10, 5, 40, 0, 0, 10, 10));
    directed.push_back(make_request(0, 0, 10, 10, 0, 10, 10, 10, 0, 0));
    directed.push_back(make_request(-32768, -32768, 32767, -32768, -32768, 32767,
                                    -32768, -32768, 32767, 32767));
    directed.push_back(make_request(32767, 32767, 32767, 32767, 32767, 32767,
                                    32767, 32767, 32767, 32767));
    directed.push_back(make_request(-32768, 32767, 32767, -32768, 32767, 32767,
                                    -32768, -32768, -1, -1));
    directed.push_back(make_request(-32768, -32768, 32767, 32767, -32768, 32767,
                                    0, -32768, 32767, -1));
    directed.push_back(make_request(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    foreach (directed[k])
      send_request(directed[k]);

    for (int n = 0; n < 1050; n++) begin
      quiet_tail = (n >= 950);
      send_request(random_request());
    end
    start <= 0;

    hold = 0;
    while (sb.pending.size() != 0 && hold < 1000) begin
      @(posedge clk);
      hold++;
    end
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
